// ===== rtl/barometric_pressure_compensation_defines.svh =====
// Assertion macros for the barometric pressure compensation block.
// Included by the RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// Shared constants, register codes and rounding helper for the pressure compensation block.
// No dependencies.
`default_nettype none

package bpc_pkg;

  localparam int DATA_W    = 64;   // working width of all fixed-point values
  localparam int PROD_W    = 128;  // full product width
  localparam int PART_W    = 32;   // operand slice width in the multiplier
  localparam int MUL_LAT   = 3;    // multiplier latency in cycles
  localparam int PIPE_LAT  = 23;   // accept edge to result strobe
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CALIB  = 8'd0,
    REG_PRESS_LOW   = 8'd1,
    REG_PRESS_MID   = 8'd2,
    REG_PRESS_HIGH  = 8'd3
  } cfg_reg_t;

  // Arithmetic shift right with round to nearest, ties away from zero
  function automatic logic signed [DATA_W-1:0] rnd_shr(input logic signed [DATA_W-1:0] x,
                                                       input int unsigned sh);
    logic signed [DATA_W-1:0] h;
    logic signed [DATA_W-1:0] y;
    h = (DATA_W'(1) << sh) >> 1;
    y = x + h - DATA_W'(x[DATA_W-1]);
    return y >>> sh;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bpc_dly.sv =====
// Fixed-depth delay line used to align operands between pipeline stages.
// No dependencies.
`default_nettype none

module bpc_dly #(
  parameter int W     = 64,
  parameter int DEPTH = 3
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  // plain shift line, payload only
  always_ff @(posedge clk) begin
    tap_r[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/bpc_mul.sv =====
// Three-stage signed 64x64 multiplier with rounded arithmetic right shift.
// Depends on bpc_pkg.
`default_nettype none

module bpc_mul #(
  parameter int SH = 0
) (
  input  wire logic                               clk,
  input  wire logic signed [bpc_pkg::DATA_W-1:0]  a,
  input  wire logic signed [bpc_pkg::DATA_W-1:0]  b,
  output logic signed      [bpc_pkg::DATA_W-1:0]  p
);
  import bpc_pkg::*;

  localparam logic [PROD_W-1:0] HALF = (PROD_W'(1) << SH) >> 1;
  localparam logic              RND  = (SH > 0);

  logic signed [PART_W:0]     a_lo, b_lo;
  logic signed [PART_W-1:0]   a_hi, b_hi;
  logic signed [2*PART_W+1:0] pp0_r, pp1_r, pp2_r, pp3_r;
  logic signed [PROD_W-1:0]   sa_r, sb_r;
  logic signed [PROD_W-1:0]   full, rnd;
  logic signed [DATA_W-1:0]   p_nxt;

  // low slices unsigned, high slices signed
  assign a_lo = $signed({1'b0, a[PART_W-1:0]});
  assign b_lo = $signed({1'b0, b[PART_W-1:0]});
  assign a_hi = a[DATA_W-1:PART_W];
  assign b_hi = b[DATA_W-1:PART_W];

  // stage 1: four partial products
  always_ff @(posedge clk) begin
    pp0_r <= a_lo * b_lo;
    pp1_r <= a_lo * b_hi;
    pp2_r <= a_hi * b_lo;
    pp3_r <= a_hi * b_hi;
  end

  // stage 2: pairwise alignment and sums
  always_ff @(posedge clk) begin
    sa_r <= PROD_W'(pp0_r) + (PROD_W'(pp1_r) <<< PART_W);
    sb_r <= (PROD_W'(pp2_r) <<< PART_W) + (PROD_W'(pp3_r) <<< (2*PART_W));
  end

  // stage 3: final sum, round half away from zero, shift
  always_comb begin
    full  = sa_r + sb_r;
    rnd   = full + $signed(HALF) - PROD_W'(RND & full[PROD_W-1]);
    p_nxt = rnd[SH +: DATA_W];
  end

  always_ff @(posedge clk) begin
    p <= p_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/barometric_pressure_compensation.sv =====
// Throughput: one sample pair per cycle while busy is low, set by the fully pipelined
// multipliers; each accepted item gives exactly one result strobe.
// The receiver cannot stall; out_strobe lasts exactly one cycle per item.
// Reset: calibration registers clear to zero, pipeline valid bits clear, busy is held
// high and cfg_ready low until the busy register samples rst_n high.
// Depends on bpc_pkg, bpc_mul, bpc_dly and the assertion macro header.
`default_nettype none

module barometric_pressure_compensation (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [23:0]                   in_raw_pressure,
  input  wire logic [23:0]                   in_raw_temperature,
  output logic                               out_strobe,
  output logic                               out_reading_valid,
  output logic signed [15:0]                 out_temperature_out,
  output logic [23:0]                        out_pressure_out,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bpc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bpc_pkg::*;
`include "barometric_pressure_compensation_defines.svh"

  localparam int DW = DATA_W;

  // ---------------- control and configuration ----------------
  logic        busy_r;
  logic [39:0] temp_calib_r;
  logic [47:0] press_low_r, press_mid_r;
  logic [31:0] press_high_r;
  logic        acc;

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign acc       = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // calibration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_low_r  <= '0;
      press_mid_r  <= '0;
      press_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEMP_CALIB: temp_calib_r <= cfg_data[39:0];
        REG_PRESS_LOW:  press_low_r  <= cfg_data;
        REG_PRESS_MID:  press_mid_r  <= cfg_data;
        REG_PRESS_HIGH: press_high_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // calibration fields
  logic [15:0]        t1, t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;
  logic signed [16:0] p1m, p2m;

  assign t1  = temp_calib_r[15:0];
  assign t2  = temp_calib_r[31:16];
  assign t3  = $signed(temp_calib_r[39:32]);
  assign p1  = $signed(press_low_r[15:0]);
  assign p2  = $signed(press_low_r[31:16]);
  assign p3  = $signed(press_low_r[39:32]);
  assign p4  = $signed(press_low_r[47:40]);
  assign p5  = press_mid_r[15:0];
  assign p6  = press_mid_r[31:16];
  assign p7  = $signed(press_mid_r[39:32]);
  assign p8  = $signed(press_mid_r[47:40]);
  assign p9  = $signed(press_high_r[15:0]);
  assign p10 = $signed(press_high_r[23:16]);
  assign p11 = $signed(press_high_r[31:24]);
  assign p1m = $signed({p1[15], p1}) - 17'sd16384;
  assign p2m = $signed({p2[15], p2}) - 17'sd16384;

  // ---------------- stage 1: input beat ----------------
  logic [PIPE_LAT-1:1] vld_r;
  logic signed [24:0]  d_r;
  logic [23:0]         rp_r;
  logic                ok_r;

  always_ff @(posedge clk) begin
    d_r  <= $signed({1'b0, in_raw_temperature}) - $signed({1'b0, t1, 8'h00});
    rp_r <= in_raw_pressure;
    ok_r <= (in_raw_pressure != '0) && (in_raw_temperature != '0);
  end

  // valid bits ride alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:1], acc};
    end
  end

  // ---------------- temperature term S (Q48) ----------------
  logic signed [DW-1:0] dt2_w, dd_w, ddt3_w, dt2_d, s_r;

  bpc_mul #(.SH(0)) u_mul_dt2 (.clk, .a(DW'(d_r)), .b(DW'(t2)), .p(dt2_w));
  bpc_mul #(.SH(0)) u_mul_dd  (.clk, .a(DW'(d_r)), .b(DW'(d_r)), .p(dd_w));
  bpc_mul #(.SH(0)) u_mul_t3  (.clk, .a(dd_w), .b(DW'(t3)), .p(ddt3_w));
  bpc_dly #(.W(DW), .DEPTH(MUL_LAT)) u_dly_dt2 (.clk, .d(dt2_w), .q(dt2_d));

  always_ff @(posedge clk) begin
    s_r <= (dt2_d <<< 18) + ddt3_w;
  end

  // temperature output, rounded and saturated
  logic signed [DW-1:0] tr;
  logic signed [15:0]   tout_r, tout_d;

  assign tr = rnd_shr(s_r, 40);

  always_ff @(posedge clk) begin
    if (tr > 64'sd32767) begin
      tout_r <= 16'sh7fff;
    end else if (tr < -64'sd32768) begin
      tout_r <= 16'sh8000;
    end else begin
      tout_r <= tr[15:0];
    end
  end

  bpc_dly #(.W(16), .DEPTH(13)) u_dly_tout (.clk, .d(tout_r), .q(tout_d));

  // ---------------- powers of temperature ----------------
  logic signed [DW-1:0] sq_w, s_d3, cu_w;

  bpc_mul #(.SH(56)) u_mul_sq (.clk, .a(s_r), .b(s_r), .p(sq_w));
  bpc_dly #(.W(DW), .DEPTH(MUL_LAT)) u_dly_s (.clk, .d(s_r), .q(s_d3));
  bpc_mul #(.SH(56)) u_mul_cu (.clk, .a(sq_w), .b(s_d3), .p(cu_w));

  // ---------------- coefficient terms ----------------
  logic signed [DW-1:0] p6s_w, p2s_w, p10s_w, p7sq_w, p3sq_w, p8cu_w, p4cu_w;
  logic signed [DW-1:0] p6s_d, p2s_d, p7sq_d, p3sq_d;

  bpc_mul #(.SH(22)) u_mul_p6  (.clk, .a(DW'(p6)),  .b(s_r),  .p(p6s_w));
  bpc_mul #(.SH(21)) u_mul_p2  (.clk, .a(DW'(p2m)), .b(s_r),  .p(p2s_w));
  bpc_mul #(.SH(16)) u_mul_p10 (.clk, .a(DW'(p10)), .b(s_r),  .p(p10s_w));
  bpc_mul #(.SH(16)) u_mul_p7  (.clk, .a(DW'(p7)),  .b(sq_w), .p(p7sq_w));
  bpc_mul #(.SH(16)) u_mul_p3  (.clk, .a(DW'(p3)),  .b(sq_w), .p(p3sq_w));
  bpc_mul #(.SH(15)) u_mul_p8  (.clk, .a(DW'(p8)),  .b(cu_w), .p(p8cu_w));
  bpc_mul #(.SH(13)) u_mul_p4  (.clk, .a(DW'(p4)),  .b(cu_w), .p(p4cu_w));

  bpc_dly #(.W(DW), .DEPTH(2*MUL_LAT)) u_dly_p6s  (.clk, .d(p6s_w),  .q(p6s_d));
  bpc_dly #(.W(DW), .DEPTH(2*MUL_LAT)) u_dly_p2s  (.clk, .d(p2s_w),  .q(p2s_d));
  bpc_dly #(.W(DW), .DEPTH(MUL_LAT))   u_dly_p7sq (.clk, .d(p7sq_w), .q(p7sq_d));
  bpc_dly #(.W(DW), .DEPTH(MUL_LAT))   u_dly_p3sq (.clk, .d(p3sq_w), .q(p3sq_d));

  // offset po1, sensitivity C and coefficient k
  logic signed [DW-1:0] po1_r, c_r, k_r;

  always_ff @(posedge clk) begin
    po1_r <= (DW'(p5) << 35) + p6s_d + p7sq_d + p8cu_w;
    c_r   <= (DW'(p1m) <<< 36) + p2s_d + p3sq_d + p4cu_w;
    k_r   <= (DW'(p9) <<< 32) + p10s_w;
  end

  // ---------------- raw pressure terms ----------------
  logic signed [DW-1:0] r2_w, rp11_w, r2_d, r2k_w, r2p_w, r2p_d, pd_r, pd_d;
  logic signed [DW-1:0] po2_w, po1_d;
  logic [23:0]          rp_d;

  bpc_mul #(.SH(0))  u_mul_r2   (.clk, .a(DW'(rp_r)), .b(DW'(rp_r)), .p(r2_w));
  bpc_mul #(.SH(0))  u_mul_rp11 (.clk, .a(DW'(rp_r)), .b(DW'(p11)),  .p(rp11_w));
  bpc_mul #(.SH(33)) u_mul_r2p  (.clk, .a(r2_w), .b(rp11_w), .p(r2p_w));
  bpc_dly #(.W(DW), .DEPTH(8)) u_dly_r2  (.clk, .d(r2_w),  .q(r2_d));
  bpc_dly #(.W(DW), .DEPTH(8)) u_dly_r2p (.clk, .d(r2p_w), .q(r2p_d));
  bpc_mul #(.SH(48)) u_mul_r2k  (.clk, .a(r2_d), .b(k_r), .p(r2k_w));

  always_ff @(posedge clk) begin
    pd_r <= r2k_w + r2p_d;
  end

  bpc_dly #(.W(DW), .DEPTH(5))  u_dly_pd  (.clk, .d(pd_r), .q(pd_d));
  bpc_dly #(.W(24), .DEPTH(17)) u_dly_rp  (.clk, .d(rp_r), .q(rp_d));
  bpc_mul #(.SH(24)) u_mul_po2 (.clk, .a(DW'(rp_d)), .b(c_r), .p(po2_w));
  bpc_dly #(.W(DW), .DEPTH(MUL_LAT)) u_dly_po1 (.clk, .d(po1_r), .q(po1_d));

  // ---------------- final sum and output beat ----------------
  logic signed [DW-1:0] sum_r, pr;
  logic                 ok_d;

  always_ff @(posedge clk) begin
    sum_r <= po1_d + po2_w + pd_d;
  end

  bpc_dly #(.W(1), .DEPTH(PIPE_LAT-2)) u_dly_ok (.clk, .d(ok_r), .q(ok_d));

  assign pr = rnd_shr(sum_r, 26);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_reading_valid   <= ok_d;
    out_temperature_out <= ok_d ? tout_d : 16'sd0;
    if (!ok_d || pr <= 64'sd0) begin
      out_pressure_out <= '0;
    end else if (pr > 64'sd16777215) begin
      out_pressure_out <= 24'hffffff;
    end else begin
      out_pressure_out <= pr[23:0];
    end
  end

  // ---------------- assertions ----------------
  `BPC_ASSERT_NOW(a_strobe_has_item, out_strobe, $past(start && !busy, PIPE_LAT), "result beat without an accepted item")
  `BPC_ASSERT_NOW(a_invalid_zero, out_strobe && !out_reading_valid, out_temperature_out == 16'sd0 && out_pressure_out == 24'd0, "invalid reading carries nonzero values")
  `BPC_ASSERT_NEXT(a_temp_cfg_write, cfg_valid && cfg_ready && cfg_index == REG_TEMP_CALIB, temp_calib_r == $past(cfg_data[39:0]), "temperature calibration write lost")

endmodule

`default_nettype wire

// ===== dv/barometric_pressure_compensation_test.sv =====
// Self-checking bench for barometric_pressure_compensation: random and directed sample beats,
// calibration sets written between phases, results checked against a fixed-point predictor.
// Depends on bpc_pkg and the block's RTL.
`default_nettype none

module barometric_pressure_compensation_test;
  import bpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // An index past the last register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd9;
  localparam int                   DRAIN_CYC    = PIPE_LAT + 8;

  typedef struct packed {
    logic [23:0] pressure;
    logic [23:0] temperature;
  } sample_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] temp;
    logic [23:0]        press;
  } reading_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
  } cfg_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [23:0] in_raw_pressure = '0;
  logic [23:0] in_raw_temperature = '0;
  logic out_strobe;
  logic out_reading_valid;
  logic signed [15:0] out_temperature_out;
  logic [23:0] out_pressure_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Calibration as the block should hold it
  logic [39:0] cal_temp = '0;
  logic [47:0] cal_plow = '0;
  logic [47:0] cal_pmid = '0;
  logic [31:0] cal_phigh = '0;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       gap_pct = 0;
  int       errors = 0;

  barometric_pressure_compensation dut (
    .clk, .rst_n, .start, .busy, .in_raw_pressure, .in_raw_temperature,
    .out_strobe, .out_reading_valid, .out_temperature_out, .out_pressure_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // round(a*b / 2^sh), ties away from zero, saturated to 64 bits
  function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input int unsigned sh);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  mag;
    ua = a[63] ? 64'(-a) : a;
    ub = b[63] ? 64'(-b) : b;
    p = {64'b0, ua} * {64'b0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    mag = (p[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
    return (a[63] ^ b[63]) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic reading_t compensate(input sample_t smp);
    logic signed [63:0] rp, rt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic signed [63:0] d, s, sq, cu, po1, c, po2, k, r2, pd, sum, tout, pout;
    reading_t r;
    r = '0;
    if (smp.pressure == '0 || smp.temperature == '0) return r;
    rp = {40'b0, smp.pressure};
    rt = {40'b0, smp.temperature};
    t1 = {48'b0, cal_temp[15:0]};
    t2 = {48'b0, cal_temp[31:16]};
    t3 = $signed(cal_temp[39:32]);
    p1 = $signed(cal_plow[15:0]);
    p2 = $signed(cal_plow[31:16]);
    p3 = $signed(cal_plow[39:32]);
    p4 = $signed(cal_plow[47:40]);
    p5 = {48'b0, cal_pmid[15:0]};
    p6 = {48'b0, cal_pmid[31:16]};
    p7 = $signed(cal_pmid[39:32]);
    p8 = $signed(cal_pmid[47:40]);
    p9 = $signed(cal_phigh[15:0]);
    p10 = $signed(cal_phigh[23:16]);
    p11 = $signed(cal_phigh[31:24]);

    // linearised temperature in Q48 and its powers
    d = rt - (t1 <<< 8);
    s = d * t2 * 64'sd262144 + d * d * t3;
    sq = scaled_product(s, s, 56);
    cu = scaled_product(sq, s, 56);

    po1 = (p5 <<< 35) + scaled_product(p6, s, 22) + scaled_product(p7, sq, 16)
        + scaled_product(p8, cu, 15);
    c = ((p1 - 64'sd16384) <<< 36) + scaled_product(p2 - 64'sd16384, s, 21)
      + scaled_product(p3, sq, 16) + scaled_product(p4, cu, 13);
    po2 = scaled_product(rp, c, 24);
    k = (p9 <<< 32) + scaled_product(p10, s, 16);
    r2 = rp * rp;
    pd = scaled_product(r2, k, 48) + scaled_product(r2, rp * p11, 33);
    sum = po1 + po2 + pd;

    tout = scaled_product(s, 64'sd1, 40);
    if (tout > 64'sd32767) tout = 64'sd32767;
    if (tout < -64'sd32768) tout = -64'sd32768;
    pout = scaled_product(sum, 64'sd1, 26);
    if (pout < 0) pout = 0;
    if (pout > 64'sd16777215) pout = 64'sd16777215;

    r.ok = 1'b1;
    r.temp = tout[15:0];
    r.press = pout[23:0];
    return r;
  endfunction

  // Sample driver: predicts on each accepted beat, then offers the next one
  always @(posedge clk) begin
    sample_t nxt;
    if (start && !busy)
      expected_readings.push_back(compensate({in_raw_pressure, in_raw_temperature}));
    if (!start || !busy) begin
      if (rst_n && pending_samples.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = pending_samples.pop_front();
        start <= 1'b1;
        in_raw_pressure <= nxt.pressure;
        in_raw_temperature <= nxt.temperature;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_strobe) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result beat valid=%0b temp=%0d press=%0d", $time,
                 out_reading_valid, out_temperature_out, out_pressure_out);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (out_reading_valid !== want.ok) begin
          $display("%0t: reading_valid expected %0b got %0b", $time, want.ok, out_reading_valid);
          errors++;
        end
        if (out_temperature_out !== want.temp) begin
          $display("%0t: temperature_out expected %0d got %0d", $time, want.temp,
                   out_temperature_out);
          errors++;
        end
        if (out_pressure_out !== want.press) begin
          $display("%0t: pressure_out expected %0d got %0d", $time, want.press,
                   out_pressure_out);
          errors++;
        end
      end
    end
  end

  // Writes a burst of calibration beats, holding valid high across the burst
  task automatic write_calibration(input cfg_beat_t beats[$]);
    foreach (beats[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= beats[i].idx;
      cfg_data <= beats[i].data;
      do @(posedge clk); while (!cfg_ready);
      case (beats[i].idx)
        REG_TEMP_CALIB: cal_temp = beats[i].data[39:0];
        REG_PRESS_LOW:  cal_plow = beats[i].data;
        REG_PRESS_MID:  cal_pmid = beats[i].data;
        REG_PRESS_HIGH: cal_phigh = beats[i].data[31:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || expected_readings.size() != 0 || start);
  endtask

  // Raw temperature near the calibration offset, sometimes anywhere
  function automatic logic [23:0] pick_temperature();
    logic [23:0] base;
    base = {cal_temp[15:0], 8'h00};
    if ($urandom_range(3) == 0) return 24'($urandom);
    return base + 24'($signed($urandom_range(2097152)) - 1048576);
  endfunction

  function automatic sample_t random_sample();
    sample_t smp;
    smp.pressure = 24'($urandom);
    smp.temperature = pick_temperature();
    case ($urandom_range(39))
      0: smp.pressure = '0;
      1: smp.temperature = '0;
      2: smp.pressure = 24'hFFFFFF;
      3: smp.temperature = 24'hFFFFFF;
      4: smp.pressure = 24'd1;
      default: ;
    endcase
    return smp;
  endfunction

  initial begin
    cfg_beat_t beats[$];
    int        gaps[5] = '{0, 71, 27, 0, 71};
    logic [47:0] typical[4];

    typical[0] = {8'hF9, 16'd19000, 16'd27776};
    typical[1] = {8'hFE, 8'd20, 16'd2000, 16'd1000};
    typical[2] = {8'hF8, 8'd3, 16'd30000, 16'd25000};
    typical[3] = {8'hF6, 8'd30, 16'd15000};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!cfg_ready);

    // Directed: reset calibration, zero and extreme samples
    pending_samples.push_back('{24'd0, 24'd0});
    pending_samples.push_back('{24'd0, 24'd5});
    pending_samples.push_back('{24'd5, 24'd0});
    pending_samples.push_back('{24'hFFFFFF, 24'hFFFFFF});
    pending_samples.push_back('{24'd1, 24'd1});
    wait_idle();

    // Directed: typical calibration, plus a dropped write to an unmapped index
    beats = {};
    for (int r = 0; r < 4; r++) beats.push_back('{cfg_reg_t'(r), typical[r]});
    beats.push_back('{REG_UNMAPPED, 48'hFFFF_FFFF_FFFF});
    write_calibration(beats);
    pending_samples.push_back('{24'd0, 24'd7110656});
    pending_samples.push_back('{24'd6000000, 24'd0});
    pending_samples.push_back('{24'd6000000, 24'd7110656});
    pending_samples.push_back('{24'd1, 24'd7110656});
    pending_samples.push_back('{24'hFFFFFF, 24'd7110656});
    pending_samples.push_back('{24'd6000000, 24'd1});
    pending_samples.push_back('{24'd6000000, 24'hFFFFFF});
    pending_samples.push_back('{24'h800000, 24'h6C8000});
    pending_samples.push_back('{24'h7FFFFF, 24'h6C8001});
    wait_idle();

    // Directed: calibration at both extremes
    for (int x = 0; x < 2; x++) begin
      beats = {};
      for (int r = 0; r < 4; r++)
        beats.push_back('{cfg_reg_t'(r), x ? 48'hFFFF_FFFF_FFFF : 48'h7F7F_7FFF_7FFF});
      write_calibration(beats);
      pending_samples.push_back('{24'hFFFFFF, 24'd1});
      pending_samples.push_back('{24'd1, 24'hFFFFFF});
      pending_samples.push_back('{24'hABCDEF, 24'h123456});
      wait_idle();
    end

    // Random phases: typical calibration perturbed, or fully random
    foreach (gaps[ph]) begin
      beats = {};
      for (int r = 0; r < 4; r++)
        beats.push_back('{cfg_reg_t'(r), (ph % 2 == 0) ? typical[r] ^ 48'($urandom_range(255))
                                                      : 48'({$urandom, $urandom})});
      write_calibration(beats);
      gap_pct = gaps[ph];
      for (int n = 0; n < 255; n++) pending_samples.push_back(random_sample());
      wait_idle();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) $display("barometric_pressure_compensation_test: PASS");
    else $display("barometric_pressure_compensation_test: FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("barometric_pressure_compensation_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
